// ===== rtl/ctw_pkg.sv =====
// Shared types, constants and compact-target expansion for the work and PoW check unit.
`default_nettype none
package ctw_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned NUM_WORDS  = 4;
    localparam int unsigned VAL_W      = 256;
    localparam int unsigned NUM_CELLS  = 64;
    localparam int unsigned CELL_STEPS = 4;
    localparam logic [31:0] LIMIT_RESET = 32'h1d00ffff;

    // One division in flight: nq shifts the dividend out at the top and the
    // quotient in at the bottom; r is the partial remainder; t is the target
    // (the divisor is t + 1).
    typedef struct packed {
        logic [VAL_W-1:0] nq;
        logic [VAL_W-1:0] r;
        logic [VAL_W-1:0] t;
        logic             tgt_ok;
        logic             pow;
    } ctw_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] t;
        logic             ok;
    } ctw_exp_t;

    // Expand a compact word to a 256-bit target and flag bad encodings
    function automatic ctw_exp_t ctw_expand(input logic [31:0] bits);
        logic [7:0]       e;
        logic [22:0]      m;
        logic             neg;
        logic             ovf;
        logic [VAL_W-1:0] base;
        logic [7:0]       sh;
        ctw_exp_t         res;
        e    = bits[31:24];
        m    = bits[22:0];
        neg  = (m != 23'd0) && bits[23];
        ovf  = (m != 23'd0) && ((e > 8'd34) || ((m > 23'h0000ff) && (e > 8'd33))
                || ((m > 23'h00ffff) && (e > 8'd32)));
        base = {{(VAL_W-23){1'b0}}, m};
        sh   = e - 8'd3;
        if (e <= 8'd3)
        begin
            unique case (e[1:0])
                2'd0:    res.t = base >> 24;
                2'd1:    res.t = base >> 16;
                2'd2:    res.t = base >> 8;
                default: res.t = base;
            endcase
        end
        else if (sh < 8'd32)
        begin
            res.t = base << {sh[4:0], 3'b000};
        end
        else
        begin
            res.t = '0;
        end
        res.ok = !(neg || ovf);
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/compact_target_work_and_pow_check_unit.sv =====
// Top level: compact target expansion, PoW check and a chain of divider cells.
`default_nettype none
// Takes a compact target word and a 256-bit hash per input word and returns the
// 256-bit work floor(~target/(target+1))+1 as four 64-bit words, least
// significant first, each tagged with the PoW verdict and the bad-encoding flag.
// Items are accepted while earlier ones are still in the divider, a row of 64
// cells, each doing 4 restoring steps (one per cycle unless the output freezes
// the chain) before passing the item on; the output sends 4 words per item. A
// write on the config port goes to limit_reg and then to its registered expansion.
module compact_target_work_and_pow_check_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [287:0] s_axis_tdata,  // target_bits, hash_word0..hash_word3
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata,  // work_word, word_index, zero pad
    output logic              m_axis_tlast,
    output logic [1:0]        m_axis_tuser   // pow_valid, target_invalid
);
    import ctw_pkg::*;

    logic [31:0]      limit_reg;
    ctw_exp_t         limit_x_reg;
    logic             in_valid_reg;
    logic [287:0]     in_data_reg;
    logic [1:0]       phase_reg;
    logic             advance;
    logic             en;
    logic             out_free;
    ctw_exp_t         tx;
    logic [VAL_W-1:0] hash;
    ctw_item_t        entry;
    logic             link_valid [0:NUM_CELLS];
    ctw_item_t        link_item  [0:NUM_CELLS];

    // limit register and its expansion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            limit_x_reg <= ctw_expand(LIMIT_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            limit_x_reg <= ctw_expand(limit_reg);
        end
    end

    // global step phase; the chain freezes when the output cannot take an item
    assign advance = (phase_reg == 2'd3);
    assign en      = !(advance && link_valid[NUM_CELLS] && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else if (en)
        begin
            phase_reg <= phase_reg + 2'd1;
        end
    end

    // input holding register
    assign s_axis_tready = !in_valid_reg || (en && advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    // expand and check the held item before it enters the chain
    always_comb
    begin
        tx           = ctw_expand(in_data_reg[31:0]);
        hash         = in_data_reg[287:32];
        entry.nq     = ~tx.t;
        entry.r      = '0;
        entry.t      = tx.t;
        entry.tgt_ok = tx.ok;
        entry.pow    = tx.ok && (tx.t != '0) && limit_x_reg.ok
                       && (tx.t <= limit_x_reg.t) && (hash <= tx.t);
    end

    assign link_valid[0] = in_valid_reg;
    assign link_item[0]  = entry;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        ctw_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .advance    (advance),
            .prev_valid (link_valid[i]),
            .prev_item  (link_item[i]),
            .step_valid (link_valid[i+1]),
            .step_item  (link_item[i+1])
        );
    end

    ctw_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (en && advance && link_valid[NUM_CELLS]),
        .item          (link_item[NUM_CELLS]),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/ctw_cell.sv =====
// Divider cell: a restoring step per cycle while enabled; hands its item on at advance.
`default_nettype none
module ctw_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               advance,
    input  wire logic               prev_valid,
    input  wire ctw_pkg::ctw_item_t prev_item,
    output logic                    step_valid,
    output ctw_pkg::ctw_item_t      step_item
);
    import ctw_pkg::*;

    logic       valid_reg;
    ctw_item_t  item_reg;
    logic [VAL_W:0] rs;
    logic [VAL_W:0] diff;
    logic           ge;

    // restoring step: compare against t + 1 as "greater than t"
    always_comb
    begin
        rs   = {item_reg.r, item_reg.nq[VAL_W-1]};
        ge   = rs > {1'b0, item_reg.t};
        diff = rs - {1'b0, item_reg.t} - {{VAL_W{1'b0}}, 1'b1};
        step_item    = item_reg;
        step_item.r  = ge ? diff[VAL_W-1:0] : rs[VAL_W-1:0];
        step_item.nq = {item_reg.nq[VAL_W-2:0], ge};
        step_valid   = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en && advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= advance ? prev_item : step_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ctw_out.sv =====
// Output stage: adds one to the quotient and sends the work as four words.
`default_nettype none
module ctw_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire ctw_pkg::ctw_item_t item,
    output logic                    free,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [71:0]             m_axis_tdata,   // work_word, word_index, zero pad
    output logic                    m_axis_tlast,
    output logic [1:0]              m_axis_tuser    // pow_valid, target_invalid
);
    import ctw_pkg::*;

    logic             valid_reg;
    logic [1:0]       cnt_reg;
    logic [VAL_W-1:0] work_reg;
    logic             pow_reg;
    logic             bad_reg;
    logic             take;

    assign take = m_axis_tvalid && m_axis_tready;
    assign free = !valid_reg || (take && (cnt_reg == 2'd3));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= 2'd0;
        end
        else if (take)
        begin
            valid_reg <= (cnt_reg != 2'd3);
            cnt_reg   <= cnt_reg + 2'd1;
        end
    end

    // work = quotient + 1, or zero for a bad encoding
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= item.tgt_ok ? (item.nq + {{(VAL_W-1){1'b0}}, 1'b1}) : '0;
            pow_reg  <= item.pow;
            bad_reg  <= !item.tgt_ok;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {6'b0, cnt_reg, work_reg[cnt_reg*WORD_W +: WORD_W]};
    assign m_axis_tlast  = (cnt_reg == 2'd3);
    assign m_axis_tuser  = {bad_reg, pow_reg};

endmodule
`default_nettype wire

// ===== dv/compact_target_work_and_pow_check_unit_tb.sv =====
// Testbench for the compact target work and PoW check unit: scoreboard and stimulus.
`timescale 1ns / 1ps

module compact_target_work_and_pow_check_unit_tb;
    import ctw_pkg::*;

    // Expected result word
    typedef struct {
        logic [63:0] work_word;
        logic [1:0]  word_index;
        logic        last_word;
        logic        pow_valid;
        logic        target_invalid;
    } work_word_t;

    // Expands a compact word; returns 1 when the encoding is legal
    function automatic bit unpack_compact(input logic [31:0] bits, output logic [255:0] tgt);
        logic [7:0]  e;
        logic [22:0] m;
        bit          neg;
        bit          ovf;
        int          s;
        e   = bits[31:24];
        m   = bits[22:0];
        neg = (m != 0) && bits[23];
        ovf = (m != 0) && (e > 34 || (m > 23'hff && e > 33) || (m > 23'hffff && e > 32));
        tgt = '0;
        if (e <= 3)
            tgt = 256'(m) >> (8 * (3 - e));
        else
        begin
            s = 8 * (e - 3);
            if (s < 256)
                tgt = 256'(m) << s;
        end
        return !(neg || ovf);
    endfunction

    class work_scoreboard;
        logic [31:0] limit_bits;
        work_word_t  pending[$];
        int          mismatches;

        function new();
            limit_bits = LIMIT_RESET;
            mismatches = 0;
        endfunction

        // Computes the four result words for one accepted input word
        function void note_item(logic [31:0] cbits, logic [255:0] hash);
            logic [255:0] tgt;
            logic [255:0] lim;
            logic [255:0] work;
            logic [256:0] div;
            bit           tok;
            bit           lok;
            bit           pow;
            work_word_t   w;
            tok  = unpack_compact(cbits, tgt);
            lok  = unpack_compact(limit_bits, lim);
            work = '0;
            pow  = 0;
            if (tok)
            begin
                div = {1'b0, tgt} + 257'd1;
                if (div[255:0] != 0 && !div[256])
                    work = (~tgt) / div[255:0] + 256'd1;
                pow = lok && tgt != 0 && tgt <= lim && hash <= tgt;
            end
            for (int k = 0; k < 4; k++)
            begin
                w.work_word      = work[64*k +: 64];
                w.word_index     = k[1:0];
                w.last_word      = (k == 3);
                w.pow_valid      = pow;
                w.target_invalid = !tok;
                pending.push_back(w);
            end
        endfunction

        // Compares one output word with the oldest expectation
        function void check_word(work_word_t got);
            work_word_t exp_w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: work=%h idx=%0d", got.work_word, got.word_index);
                return;
            end
            exp_w = pending.pop_front();
            if (got.work_word !== exp_w.work_word || got.word_index !== exp_w.word_index
                || got.last_word !== exp_w.last_word || got.pow_valid !== exp_w.pow_valid
                || got.target_invalid !== exp_w.target_invalid)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp work=%h idx=%0d last=%b pow=%b inv=%b",
                             exp_w.work_word, exp_w.word_index, exp_w.last_word,
                             exp_w.pow_valid, exp_w.target_invalid,
                             " / got work=%h idx=%0d last=%b pow=%b inv=%b",
                             got.work_word, got.word_index, got.last_word,
                             got.pow_valid, got.target_invalid);
            end
        endfunction
    endclass

    localparam int LATENCY = 300;
    localparam int LIMIT_CYCLES = 400000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata;   // target_bits, hash_word0..hash_word3
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;   // work_word, word_index, zero pad
    logic         m_axis_tlast;
    logic [1:0]   m_axis_tuser;   // pow_valid, target_invalid

    work_scoreboard sb;
    int  cycles;
    bit  no_idle;       // idling off for a stretch
    bit  hold_sink;     // long receiver hold-off

    compact_target_work_and_pow_check_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_sink && (no_idle || $urandom_range(99) >= 29);
    end

    // Output monitor
    always @(posedge clk)
    begin
        work_word_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.work_word      = m_axis_tdata[63:0];
            got.word_index     = m_axis_tdata[65:64];
            got.last_word      = m_axis_tlast;
            got.pow_valid      = m_axis_tuser[0];
            got.target_invalid = m_axis_tuser[1];
            sb.check_word(got);
        end
    end

    // Writes the limit register while idle
    task automatic write_limit(input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.limit_bits = val;
        @(posedge clk);
    endtask

    // Offers one word and waits for acceptance; valid stays up for a following word
    task automatic send_item(input logic [31:0] cbits, input logic [255:0] hash);
        while (!no_idle && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hash, cbits};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(cbits, hash);
    endtask

    // Waits until every expected word has arrived, plus a settle period
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic [255:0] rand_hash();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Mostly well-formed compact words, some raw noise
    function automatic logic [31:0] rand_compact();
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(9))
            0, 1: ;
            2:    c[31:24] = 8'($urandom_range(3));
            default:
            begin
                c[31:24] = 8'($urandom_range(4, 34));
                c[23]    = ($urandom_range(7) == 0);
            end
        endcase
        return c;
    endfunction

    // Random hash, or one at, below or just above the target, so that pow_valid is exercised both ways
    function automatic logic [255:0] hash_for(logic [31:0] c);
        logic [255:0] tgt;
        logic [255:0] h;
        void'(unpack_compact(c, tgt));
        h = rand_hash();
        case ($urandom_range(3))
            0:       return h;
            1:       return tgt;
            2:       return (tgt == 0) ? h : h % tgt;
            default: return tgt + 256'd1;
        endcase
    endfunction

    task automatic random_phase(input int n);
        logic [31:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = rand_compact();
            send_item(c, hash_for(c));
        end
    endtask

    initial
    begin
        logic [31:0] directed[$];
        sb            = new();
        cycles        = 0;
        no_idle       = 0;
        hold_sink     = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (LATENCY) @(posedge clk);

        // Directed: zero target, small exponents, sign, overflow edges, limit itself
        directed = '{32'h00000000, 32'h01003456, 32'h02123456, 32'h03123456, 32'h04000001,
                     32'h1d00ffff, 32'h1d010000, 32'h1c7fffff, 32'h04800001, 32'h04800000,
                     32'h22000001, 32'h22000100, 32'h21000100, 32'h21010000, 32'h20010000,
                     32'h207fffff, 32'h23000001, 32'hff000000, 32'hff7fffff, 32'hffffffff,
                     32'h00ffffff, 32'h037fffff};
        foreach (directed[i])
            send_item(directed[i], (i % 2) ? '1 : hash_for(directed[i]));
        send_item(32'h1d00ffff, '0);
        send_item(32'h1d00ffff, {32'h0, 32'hffff, 192'h0});
        send_item(32'h1d00ffff, {32'h0, 32'hffff, 192'h1});
        drain();

        // Random with default limit, then a long idle-free stretch
        random_phase(80);
        no_idle = 1;
        random_phase(50);
        no_idle = 0;
        drain();

        // A wide legal limit, with a receiver hold-off while the sender keeps going
        write_limit(32'h2000ffff);
        fork
            begin
                hold_sink = 1;
                repeat (1500) @(posedge clk);
                hold_sink = 0;
            end
            random_phase(80);
        join
        drain();

        // Invalid limit (negative), then a zero limit, another negative one and a random one
        write_limit(32'h1d80ffff);
        random_phase(40);
        drain();
        write_limit(32'h00000000);
        random_phase(30);
        drain();
        write_limit(32'hffffffff);
        random_phase(30);
        drain();
        write_limit($urandom);
        random_phase(30);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
